// ===== design/shd3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shd3_pkg: shared types and constants of the 3x3 heat diffusion stencil
// Item and result structs, opcodes, register indexes, reset values and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package shd3_pkg;

  // Default grid edge length (cells per row and per column)
  localparam int GRID_DEFAULT = 64;

  // Opcodes of an input item
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_PASS_COUNT     = 3'd0;
  localparam logic [2:0] REG_BOUNDARY_VALUE = 3'd1;
  localparam logic [2:0] REG_CORNER_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_EDGE_WEIGHT    = 3'd3;
  localparam logic [2:0] REG_CENTER_WEIGHT  = 3'd4;

  // Register reset values
  localparam logic [15:0] PASS_COUNT_RST     = 16'd100;
  localparam logic [31:0] BOUNDARY_VALUE_RST = 32'd1966080;  // 30.0
  localparam logic [15:0] CORNER_WEIGHT_RST  = 16'd3277;     // 0.05
  localparam logic [15:0] EDGE_WEIGHT_RST    = 16'd6554;     // 0.1
  localparam logic [15:0] CENTER_WEIGHT_RST  = 16'd26214;    // 0.4

  // Stencil taps in raster order over the 3x3 window
  localparam logic [3:0] TAP_FIRST  = 4'd0;
  localparam logic [3:0] TAP_CENTER = 4'd4;
  localparam logic [3:0] TAP_LAST   = 4'd8;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] cell_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cell_out;
    logic               saturated;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       ld_we;      // write the input cell to the active bank, clear flag
    logic       rd_cap;     // capture the input address for a read
    logic       tap_issue;  // fetch one stencil tap
    logic [3:0] tap;        // tap index, raster order
    logic       acc_clr;    // clear the accumulator
    logic       wr_cell;    // write the rounded sum to the idle bank
    logic       swap;       // swap the banks
    logic       res_load;   // result of a load item
    logic       res_zero;   // zero result carrying the flag
    logic       res_read;   // result of a read item
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/shd3_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shd3_ctrl: sequencer of the stencil unit
// Decodes items, walks the grid cell by cell and the 3x3 taps of each cell,
// counts passes and issues datapath commands.
// ----------------------------------------------------------------------------
module shd3_ctrl #(
  parameter int GRID = shd3_pkg::GRID_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                op,
  input  wire logic [15:0]               pass_count,
  output logic                           busy,
  output shd3_pkg::cmd_t                 cmd,
  output logic [$clog2(GRID)-1:0]        cell_r,
  output logic [$clog2(GRID)-1:0]        cell_c
);

  localparam int AW = $clog2(GRID);
  localparam logic [AW-1:0] LAST = AW'(GRID - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_TAP, S_DRAIN, S_WRITE, S_DONE
  } state_t;

  state_t      state;
  logic [3:0]  tap;
  logic        drain;
  logic [15:0] pass;
  logic        accept;
  logic        last_cell;

  assign accept    = (state == S_IDLE) && start;
  assign last_cell = (cell_r == LAST) && (cell_c == LAST);
  assign busy      = (state != S_IDLE);

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.tap       = tap;
    cmd.ld_we     = accept && (op == shd3_pkg::OP_LOAD);
    cmd.res_load  = accept && (op == shd3_pkg::OP_LOAD);
    cmd.rd_cap    = accept && (op == shd3_pkg::OP_READ);
    cmd.tap_issue = (state == S_TAP);
    cmd.acc_clr   = (state == S_IDLE) || (state == S_WRITE);
    cmd.wr_cell   = (state == S_WRITE);
    cmd.swap      = (state == S_WRITE) && last_cell;
    cmd.res_read  = (state == S_READ);
    cmd.res_zero  = (state == S_DONE) ||
                    (accept && (op != shd3_pkg::OP_LOAD) && (op != shd3_pkg::OP_READ) &&
                     ((op != shd3_pkg::OP_RUN) || (pass_count == 16'd0)));
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tap    <= shd3_pkg::TAP_FIRST;
      drain  <= 1'b0;
      pass   <= '0;
      cell_r <= '0;
      cell_c <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          tap    <= shd3_pkg::TAP_FIRST;
          pass   <= '0;
          cell_r <= '0;
          cell_c <= '0;
          if (start && op == shd3_pkg::OP_READ) begin
            state <= S_READ;
          end else if (start && op == shd3_pkg::OP_RUN && pass_count != 16'd0) begin
            state <= S_TAP;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_TAP: begin
          if (tap == shd3_pkg::TAP_LAST) begin
            tap   <= shd3_pkg::TAP_FIRST;
            drain <= 1'b0;
            state <= S_DRAIN;
          end else begin
            tap <= tap + 4'd1;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_TAP;
          if (cell_c == LAST) begin
            cell_c <= '0;
            if (cell_r == LAST) begin
              cell_r <= '0;
              pass   <= pass + 16'd1;
              if ({1'b0, pass} + 17'd1 == {1'b0, pass_count}) begin
                state <= S_DONE;
              end
            end else begin
              cell_r <= cell_r + AW'(1);
            end
          end else begin
            cell_c <= cell_c + AW'(1);
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/shd3_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shd3_datapath: banks, configuration registers and stencil arithmetic
// Two grid banks, a tap fetch stage, one multiplier, an accumulator and the
// round and saturate stage, plus the result register.
// ----------------------------------------------------------------------------
module shd3_datapath #(
  parameter int GRID = shd3_pkg::GRID_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire shd3_pkg::cmd_t            cmd,
  input  wire logic [$clog2(GRID)-1:0]   cell_r,
  input  wire logic [$clog2(GRID)-1:0]   cell_c,
  input  wire shd3_pkg::in_item_t        in_item,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  output logic [15:0]                    pass_count,
  output shd3_pkg::result_t              result,
  output logic                           done
);

  localparam int AW    = $clog2(GRID);
  localparam int CELLS = GRID * GRID;
  localparam int MAW   = $clog2(CELLS);
  localparam logic [AW-1:0] LAST = AW'(GRID - 1);

  logic signed [31:0] boundary_value;
  logic [15:0]        corner_weight;
  logic [15:0]        edge_weight;
  logic [15:0]        center_weight;

  logic               active;
  logic               sat_flag;

  logic [31:0]        mem_a [CELLS];
  logic [31:0]        mem_b [CELLS];
  logic [31:0]        q_a;
  logic [31:0]        q_b;
  logic [31:0]        q_src;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count     <= shd3_pkg::PASS_COUNT_RST;
      boundary_value <= shd3_pkg::BOUNDARY_VALUE_RST;
      corner_weight  <= shd3_pkg::CORNER_WEIGHT_RST;
      edge_weight    <= shd3_pkg::EDGE_WEIGHT_RST;
      center_weight  <= shd3_pkg::CENTER_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shd3_pkg::REG_PASS_COUNT:     pass_count     <= cfg_data[15:0];
        shd3_pkg::REG_BOUNDARY_VALUE: boundary_value <= cfg_data;
        shd3_pkg::REG_CORNER_WEIGHT:  corner_weight  <= cfg_data[15:0];
        shd3_pkg::REG_EDGE_WEIGHT:    edge_weight    <= cfg_data[15:0];
        shd3_pkg::REG_CENTER_WEIGHT:  center_weight  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Item address
  logic           in_inside;
  logic [MAW-1:0] in_addr;
  assign in_inside = (32'(in_item.row) < GRID) && (32'(in_item.col) < GRID);
  assign in_addr   = MAW'(32'(in_item.row) * GRID + 32'(in_item.col));

  // Tap decode: neighbour offsets and weight class
  logic up, dn, lf, rt;
  logic [15:0] tap_w;
  always_comb begin
    up = 1'b0; dn = 1'b0; lf = 1'b0; rt = 1'b0;
    tap_w = edge_weight;
    unique case (cmd.tap)
      4'd0: begin up = 1'b1; lf = 1'b1; tap_w = corner_weight; end
      4'd1: begin up = 1'b1; end
      4'd2: begin up = 1'b1; rt = 1'b1; tap_w = corner_weight; end
      4'd3: begin lf = 1'b1; end
      shd3_pkg::TAP_CENTER: begin tap_w = center_weight; end
      4'd5: begin rt = 1'b1; end
      4'd6: begin dn = 1'b1; lf = 1'b1; tap_w = corner_weight; end
      4'd7: begin dn = 1'b1; end
      4'd8: begin dn = 1'b1; rt = 1'b1; tap_w = corner_weight; end
      default: ;
    endcase
  end

  logic [AW-1:0]  nb_r, nb_c;
  logic           nb_out;
  logic [MAW-1:0] nb_addr;
  assign nb_r    = up ? cell_r - AW'(1) : (dn ? cell_r + AW'(1) : cell_r);
  assign nb_c    = lf ? cell_c - AW'(1) : (rt ? cell_c + AW'(1) : cell_c);
  assign nb_out  = (up && cell_r == '0) || (dn && cell_r == LAST) ||
                   (lf && cell_c == '0) || (rt && cell_c == LAST);
  assign nb_addr = MAW'(32'(nb_r) * GRID + 32'(nb_c));

  logic [MAW-1:0] rd_addr;
  logic [MAW-1:0] wr_addr;
  assign rd_addr = cmd.tap_issue ? nb_addr : in_addr;
  assign wr_addr = MAW'(32'(cell_r) * GRID + 32'(cell_c));

  // Round and saturate of the finished sum
  logic signed [53:0] acc;
  logic signed [53:0] acc_rnd;
  logic signed [37:0] q_full;
  logic               q_sat;
  logic [31:0]        q_val;
  assign acc_rnd = acc + 54'sd32768;
  assign q_full  = acc_rnd[53:16];
  assign q_sat   = (q_full[37:31] != '0) && (q_full[37:31] != '1);
  assign q_val   = q_sat ? (q_full[37] ? 32'h8000_0000 : 32'h7FFF_FFFF) : q_full[31:0];

  // Bank writes: loads to the active bank, pass results to the idle bank
  logic we_a, we_b;
  logic [MAW-1:0] wa;
  logic [31:0]    wd;
  assign we_a = (cmd.ld_we && in_inside && !active) || (cmd.wr_cell && active);
  assign we_b = (cmd.ld_we && in_inside && active) || (cmd.wr_cell && !active);
  assign wa   = cmd.wr_cell ? wr_addr : in_addr;
  assign wd   = cmd.wr_cell ? q_val : in_item.cell_in;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa] <= wd;
    end
    q_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wa] <= wd;
    end
    q_b <= mem_b[rd_addr];
  end

  assign q_src = active ? q_b : q_a;

  // Bank select and sticky saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      sat_flag <= 1'b0;
    end else begin
      if (cmd.swap) begin
        active <= ~active;
      end
      if (cmd.ld_we) begin
        sat_flag <= 1'b0;
      end else if (cmd.wr_cell && q_sat) begin
        sat_flag <= 1'b1;
      end
    end
  end

  // Tap pipeline: fetch, multiply, accumulate
  logic               s1_valid, s2_valid;
  logic               s1_out;
  logic [15:0]        s1_w;
  logic signed [48:0] prod;
  logic signed [31:0] operand;
  logic               rd_inside;

  assign operand = s1_out ? boundary_value : signed'(q_src);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.tap_issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_out <= nb_out;
    s1_w   <= tap_w;
    prod   <= 49'(operand * signed'({1'b0, s1_w}));
    if (cmd.rd_cap) begin
      rd_inside <= in_inside;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + 54'(prod);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load || cmd.res_zero || cmd.res_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.cell_out  <= '0;
      result.saturated <= 1'b0;
    end else if (cmd.res_read) begin
      result.cell_out  <= rd_inside ? signed'(q_src) : boundary_value;
      result.saturated <= sat_flag;
    end else begin
      result.cell_out  <= '0;
      result.saturated <= sat_flag;
    end
  end

endmodule
`default_nettype wire

// ===== design/stencil_heat_diffusion_3x3_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stencil_heat_diffusion_3x3_unit: Jacobi 3x3 heat diffusion engine
// Two-bank grid of Q16.16 temperatures; load, run and read items.
//
//   channel   handshake            payload
//   item      start / busy         in_item  (op, row, col, cell_in)
//   result    done strobe          result   (cell_out, saturated)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load, undefined and zero-pass run items: result next cycle, back to back.
// Read: the bank output and then the result are registered; busy in between.
// Run: for every cell, nine taps through one multiplier, a pipeline drain and
// one write, repeated over GRID*GRID cells and pass_count passes.
// Reset is synchronous; the banks are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module stencil_heat_diffusion_3x3_unit #(
  parameter int GRID = shd3_pkg::GRID_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire shd3_pkg::in_item_t  in_item,
  output logic                     done,
  output shd3_pkg::result_t        result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  localparam int AW = $clog2(GRID);

  shd3_pkg::cmd_t cmd;
  logic [AW-1:0]  cell_r;
  logic [AW-1:0]  cell_c;
  logic [15:0]    pass_count;

  assign cfg_ready = 1'b1;

  shd3_ctrl #(.GRID(GRID)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (in_item.op),
    .pass_count (pass_count),
    .busy       (busy),
    .cmd        (cmd),
    .cell_r     (cell_r),
    .cell_c     (cell_c)
  );

  shd3_datapath #(.GRID(GRID)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cell_r     (cell_r),
    .cell_c     (cell_c),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pass_count (pass_count),
    .result     (result),
    .done       (done)
  );

endmodule
`default_nettype wire
